// File: sv/lsfe_pkg.sv
// lsfe_pkg: shared constants and types for the lighting scene fade engine
// used by every module of the block; no dependencies

package lsfe_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_IDX_W = 4;

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_DEL       = 3'd1;
  localparam logic [2:0] OP_FADE_IN   = 3'd2;
  localparam logic [2:0] OP_FADE_OUT  = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_IN      = 2'd1;
  localparam logic [1:0] MODE_OUT     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FADE_IN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT = CFG_IDX_W'(1);

  typedef struct packed {
    logic capture;
    logic tick_begin;
    logic rd;
    logic scan;
    logic mul;
    logic div_step;
    logic emit_chan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] op;
    logic       fading;
    logic       cnt_zero;
    logic       idx_end;
    logic       div_last;
    logic       out_free;
  } stat_t;

endpackage

// File: sv/lsfe_in_if.sv
// lsfe_in_if: input item channel with valid/ready handshake
// depends on nothing

interface lsfe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [15:0] fix_id;
  logic [9:0]  base_address;
  logic [8:0]  channel_offset;
  logic [7:0]  level;
  logic        first_of_preset;

  modport source (output valid, op, fix_id, base_address, channel_offset, level,
                  first_of_preset, input ready);
  modport sink (input valid, op, fix_id, base_address, channel_offset, level,
                first_of_preset, output ready);
endinterface

// File: sv/lsfe_out_if.sv
// lsfe_out_if: result item channel with valid/ready handshake
// depends on nothing

interface lsfe_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       channel_valid;
  logic [9:0] address;
  logic [7:0] value;
  logic       last;

  modport source (output valid, status, channel_valid, address, value, last, input ready);
  modport sink (input valid, status, channel_valid, address, value, last, output ready);
endinterface

// File: sv/lsfe_cfg_if.sv
// lsfe_cfg_if: configuration write channel with valid/ready handshake
// depends on lsfe_pkg for the index width

interface lsfe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lsfe_pkg::CFG_IDX_W-1:0] index;
  logic [15:0]                    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/lighting_scene_fade_engine_core.sv
// lighting_scene_fade_engine_core: top level of the scene fade engine
// depends on lsfe_pkg, lsfe_in_if, lsfe_out_if, lsfe_cfg_if, lsfe_ctrl, lsfe_dp
//
// Usage:
//   in_ch carries one op per transfer: add entry, delete fixture, start fade-in,
//   start fade-out or a one-millisecond tick. out_ch carries the results; every
//   op gives one result except a tick during a fade with a non-empty table, which
//   gives one result per stored entry in table order, the final one flagged by last.
//   cfg_ch writes fade_in_ms (index 0) or fade_out_ms (index 1); it is always ready.
//   One op is worked at a time; in_ch is ready again once the previous op's
//   last result has been loaded into the output register.
//   Start fade and unknown ops do not scan the table; add and delete scan the
//   table with one memory read port.
//   A fading tick works each entry in turn: one read, one 8x16 multiply,
//   8 steps of the shared restoring divider and one output load.
//   If the receiver stalls, the result waits in the output register and the
//   sequencer holds until it is taken.
//   Reset (synchronous, active low) empties the table, stops any fade, clears
//   both durations and drops pending results; the table memory is not cleared.

module lighting_scene_fade_engine_core (
  input logic        clk,
  input logic        rst_n,
  lsfe_in_if.sink    in_ch,
  lsfe_out_if.source out_ch,
  lsfe_cfg_if.sink   cfg_ch
);

  lsfe_pkg::cmd_t  cmd;
  lsfe_pkg::stat_t stat;

  assign cfg_ch.ready = 1'b1;

  lsfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ch.ready)
  );

  lsfe_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_valid           (in_ch.valid),
    .in_op              (in_ch.op),
    .in_fix_id          (in_ch.fix_id),
    .in_base_address    (in_ch.base_address),
    .in_channel_offset  (in_ch.channel_offset),
    .in_level           (in_ch.level),
    .in_first_of_preset (in_ch.first_of_preset),
    .cfg_valid          (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_status         (out_ch.status),
    .out_channel_valid  (out_ch.channel_valid),
    .out_address        (out_ch.address),
    .out_value          (out_ch.value),
    .out_last           (out_ch.last)
  );

endmodule

// File: sv/lsfe_ctrl.sv
// lsfe_ctrl: sequencer for table scans, compaction and fade ticks
// depends on lsfe_pkg for command and status structs

module lsfe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  lsfe_pkg::stat_t   stat,
  output lsfe_pkg::cmd_t    cmd,
  output logic              in_ready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (stat.in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.op == lsfe_pkg::OP_TICK && stat.fading) begin
          cmd.tick_begin = 1'b1;
          state_nxt = stat.cnt_zero ? S_FIN : S_RD;
        end else if (stat.op == lsfe_pkg::OP_ADD || stat.op == lsfe_pkg::OP_DEL) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RD: begin
        if (stat.idx_end) begin
          state_nxt = (stat.op == lsfe_pkg::OP_TICK) ? S_IDLE : S_FIN;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.op == lsfe_pkg::OP_TICK) begin
          cmd.mul = 1'b1;
          state_nxt = S_DIV;
        end else begin
          cmd.scan = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_chan = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// File: sv/lsfe_dp.sv
// lsfe_dp: entry table memory, fade timing, multiply and divide unit, result register
// depends on lsfe_pkg for constants and command and status structs

module lsfe_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lsfe_pkg::cmd_t                 cmd,
  output lsfe_pkg::stat_t                stat,
  input  logic                           in_valid,
  input  logic [2:0]                     in_op,
  input  logic [15:0]                    in_fix_id,
  input  logic [9:0]                     in_base_address,
  input  logic [8:0]                     in_channel_offset,
  input  logic [7:0]                     in_level,
  input  logic                           in_first_of_preset,
  input  logic                           cfg_valid,
  input  logic [lsfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic                           out_channel_valid,
  output logic [9:0]                     out_address,
  output logic [7:0]                     out_value,
  output logic                           out_last
);

  localparam int IW = lsfe_pkg::IDX_W;
  localparam int CW = lsfe_pkg::CNT_W;

  logic [15:0] mem_fix [lsfe_pkg::MAX_ENTRIES];
  logic [8:0]  mem_adr [lsfe_pkg::MAX_ENTRIES];
  logic [7:0]  mem_lvl [lsfe_pkg::MAX_ENTRIES];

  logic [15:0] fade_in_r, fade_out_r;
  logic [CW-1:0] count_r, idx_r, wptr_r;
  logic [1:0]  mode_r;
  logic [15:0] elapsed_r, open_fix_r, dur_r;
  logic        open_valid_r, found_r, done_r;
  logic [2:0]  op_r;
  logic [15:0] fid_r;
  logic [9:0]  base_r;
  logic [8:0]  off_r;
  logic [7:0]  lvl_r;
  logic        first_r;
  logic [15:0] q_fix;
  logic [8:0]  q_adr;
  logic [7:0]  q_lvl;
  logic [23:0] rem_r;
  logic [7:0]  quo_r;
  logic [2:0]  bit_r;
  logic        out_valid_r;

  logic [10:0] sum;
  logic        bad_addr, is_last, fix_hit, add_ok, do_wr_add, do_wr_cmp;
  logic [2:0]  add_st, fin_st;
  logic [15:0] el_inc, dur_now;
  logic [23:0] dsh;
  logic [7:0]  val;

  assign sum = {1'b0, base_r} + {2'b0, off_r};
  assign bad_addr = (base_r == 10'd0) || (sum > 11'd512);
  assign fix_hit = (q_fix == fid_r);
  assign is_last = ((idx_r + CW'(1)) == count_r);
  assign el_inc = (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
  assign dur_now = (mode_r == lsfe_pkg::MODE_IN) ? fade_in_r : fade_out_r;
  assign dsh = 24'(dur_r) << bit_r;

  always_comb begin
    if (bad_addr) add_st = lsfe_pkg::ST_INVALID;
    else if (first_r && found_r) add_st = lsfe_pkg::ST_DUP;
    else if (!first_r && (!open_valid_r || open_fix_r != fid_r)) add_st = lsfe_pkg::ST_INVALID;
    else if (count_r == CW'(lsfe_pkg::MAX_ENTRIES)) add_st = lsfe_pkg::ST_FULL;
    else add_st = lsfe_pkg::ST_OK;
    add_ok = (add_st == lsfe_pkg::ST_OK);
    case (op_r)
      lsfe_pkg::OP_ADD: fin_st = add_st;
      lsfe_pkg::OP_DEL: fin_st = found_r ? lsfe_pkg::ST_OK : lsfe_pkg::ST_NOT_FOUND;
      lsfe_pkg::OP_FADE_IN, lsfe_pkg::OP_FADE_OUT, lsfe_pkg::OP_TICK: fin_st = lsfe_pkg::ST_OK;
      default: fin_st = lsfe_pkg::ST_INVALID;
    endcase
    if (done_r) val = (mode_r == lsfe_pkg::MODE_IN) ? q_lvl : 8'd0;
    else if (mode_r == lsfe_pkg::MODE_IN) val = quo_r;
    else val = q_lvl - quo_r;
  end

  assign do_wr_add = cmd.finish && (op_r == lsfe_pkg::OP_ADD) && add_ok;
  assign do_wr_cmp = cmd.scan && (op_r == lsfe_pkg::OP_DEL) && !fix_hit;

  // table memory
  always_ff @(posedge clk) begin
    if (do_wr_add) begin
      mem_fix[count_r[IW-1:0]] <= fid_r;
      mem_adr[count_r[IW-1:0]] <= 9'(sum - 11'd1);
      mem_lvl[count_r[IW-1:0]] <= lvl_r;
    end else if (do_wr_cmp) begin
      mem_fix[wptr_r[IW-1:0]] <= q_fix;
      mem_adr[wptr_r[IW-1:0]] <= q_adr;
      mem_lvl[wptr_r[IW-1:0]] <= q_lvl;
    end
    if (cmd.rd) begin
      q_fix <= mem_fix[idx_r[IW-1:0]];
      q_adr <= mem_adr[idx_r[IW-1:0]];
      q_lvl <= mem_lvl[idx_r[IW-1:0]];
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      fid_r <= in_fix_id;
      base_r <= in_base_address;
      off_r <= in_channel_offset;
      lvl_r <= in_level;
      first_r <= in_first_of_preset;
    end
    if (cmd.tick_begin) begin
      dur_r <= dur_now;
      done_r <= (el_inc >= dur_now);
    end
    if (cmd.mul) begin
      rem_r <= 24'(q_lvl) * 24'(elapsed_r);
      quo_r <= 8'd0;
      bit_r <= 3'd7;
    end else if (cmd.div_step) begin
      if (rem_r >= dsh) begin
        rem_r <= rem_r - dsh;
        quo_r[bit_r] <= 1'b1;
      end
      bit_r <= bit_r - 3'd1;
    end
    if (cmd.emit_chan) begin
      out_status <= lsfe_pkg::ST_OK;
      out_channel_valid <= 1'b1;
      out_address <= {1'b0, q_adr} + 10'd1;
      out_value <= val;
      out_last <= is_last;
    end else if (cmd.finish) begin
      out_status <= fin_st;
      out_channel_valid <= 1'b0;
      out_address <= 10'd0;
      out_value <= 8'd0;
      out_last <= 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_in_r <= 16'd0;
      fade_out_r <= 16'd0;
      count_r <= '0;
      idx_r <= '0;
      wptr_r <= '0;
      found_r <= 1'b0;
      mode_r <= lsfe_pkg::MODE_IDLE;
      elapsed_r <= 16'd0;
      open_fix_r <= 16'd0;
      open_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == lsfe_pkg::REG_FADE_IN) fade_in_r <= cfg_data;
      if (cfg_valid && cfg_index == lsfe_pkg::REG_FADE_OUT) fade_out_r <= cfg_data;
      if (cmd.capture) begin
        idx_r <= '0;
        wptr_r <= '0;
        found_r <= 1'b0;
      end
      if (cmd.scan) begin
        idx_r <= idx_r + CW'(1);
        if (fix_hit) found_r <= 1'b1;
        if (do_wr_cmp) wptr_r <= wptr_r + CW'(1);
      end
      if (cmd.tick_begin) elapsed_r <= el_inc;
      if (cmd.emit_chan) begin
        idx_r <= idx_r + CW'(1);
        if (is_last && done_r) mode_r <= lsfe_pkg::MODE_IDLE;
      end
      if (cmd.finish) begin
        case (op_r)
          lsfe_pkg::OP_ADD: begin
            if (add_ok) begin
              count_r <= count_r + CW'(1);
              if (first_r) begin
                open_fix_r <= fid_r;
                open_valid_r <= 1'b1;
              end
            end else if (first_r) begin
              open_valid_r <= 1'b0;
            end
          end
          lsfe_pkg::OP_DEL: begin
            count_r <= wptr_r;
            if (open_fix_r == fid_r) open_valid_r <= 1'b0;
          end
          lsfe_pkg::OP_FADE_IN: begin
            elapsed_r <= 16'd0;
            mode_r <= lsfe_pkg::MODE_IN;
          end
          lsfe_pkg::OP_FADE_OUT: begin
            elapsed_r <= 16'd0;
            mode_r <= lsfe_pkg::MODE_OUT;
          end
          lsfe_pkg::OP_TICK: begin
            if (mode_r != lsfe_pkg::MODE_IDLE && done_r) mode_r <= lsfe_pkg::MODE_IDLE;
          end
          default: ;
        endcase
      end
      if (cmd.emit_chan || cmd.finish) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  assign stat.in_valid = in_valid;
  assign stat.op = op_r;
  assign stat.fading = (mode_r != lsfe_pkg::MODE_IDLE);
  assign stat.cnt_zero = (count_r == '0);
  assign stat.idx_end = (idx_r == count_r);
  assign stat.div_last = (bit_r == 3'd0);
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

// File: sv/lsfe_checker.sv
// lsfe_checker: port-level assertions for the scene fade engine, bound to the top
// depends on lsfe_pkg and the lighting_scene_fade_engine_core ports

module lsfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic       out_channel_valid,
  input logic [9:0] out_address,
  input logic [7:0] out_value,
  input logic       out_last
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_address) && $stable(out_value))
    else $error("result changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_channel_valid |-> out_address == 10'd0 && out_value == 8'd0 && out_last)
    else $error("status-only result carries channel data");

  a_chan_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_channel_valid |-> out_status == lsfe_pkg::ST_OK && out_address != 10'd0)
    else $error("channel update with bad status or address");

endmodule

bind lighting_scene_fade_engine_core lsfe_checker u_lsfe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_channel_valid (out_ch.channel_valid),
  .out_address       (out_ch.address),
  .out_value         (out_ch.value),
  .out_last          (out_ch.last)
);

// File: sim/lsfe_scoreboard.sv
// lsfe_scoreboard: watches the input, result and configuration channels of the
// fade engine, predicts every result and compares it
// depends on lsfe_pkg and the lsfe_*_if interfaces

module lsfe_scoreboard (
  input  logic clk,
  input  logic rst_n,
  lsfe_in_if   in_ch,
  lsfe_out_if  out_ch,
  lsfe_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending,
  output int   results_seen
);

  typedef struct packed {
    logic [2:0] status;
    logic       channel_valid;
    logic [9:0] address;
    logic [7:0] value;
    logic       last;
  } chan_result_t;

  chan_result_t expected_q[$];

  logic [15:0] tbl_fixture [lsfe_pkg::MAX_ENTRIES];
  logic [8:0]  tbl_address [lsfe_pkg::MAX_ENTRIES];
  logic [7:0]  tbl_level   [lsfe_pkg::MAX_ENTRIES];
  int          tbl_count;
  logic [1:0]  mode;
  logic [15:0] elapsed;
  logic [15:0] open_fid;
  logic        open_v;
  logic [15:0] fade_in_dur;
  logic [15:0] fade_out_dur;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic push_result(input logic [2:0] st, input logic cv, input logic [9:0] a,
                             input logic [7:0] v, input logic l);
    chan_result_t r;
    r.status = st;
    r.channel_valid = cv;
    r.address = a;
    r.value = v;
    r.last = l;
    expected_q.push_back(r);
  endtask

  function automatic bit fixture_present(input logic [15:0] fid);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_fixture[i] == fid) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [2:0] apply_add(input logic [15:0] fid, input logic [9:0] base,
                                           input logic [8:0] off, input logic [7:0] lvl,
                                           input logic first);
    logic [10:0] addr;
    logic [2:0]  st;
    addr = {1'b0, base} + {2'b0, off};
    st = lsfe_pkg::ST_OK;
    if (base == 0 || addr > 11'd512) st = lsfe_pkg::ST_INVALID;
    else if (first && fixture_present(fid)) st = lsfe_pkg::ST_DUP;
    else if (!first && (!open_v || open_fid != fid)) st = lsfe_pkg::ST_INVALID;
    else if (tbl_count >= lsfe_pkg::MAX_ENTRIES) st = lsfe_pkg::ST_FULL;
    if (st != lsfe_pkg::ST_OK) begin
      if (first) open_v = 1'b0;
      return st;
    end
    tbl_fixture[tbl_count] = fid;
    tbl_address[tbl_count] = 9'(addr - 11'd1);
    tbl_level[tbl_count] = lvl;
    tbl_count++;
    if (first) begin
      open_fid = fid;
      open_v = 1'b1;
    end
    return lsfe_pkg::ST_OK;
  endfunction

  function automatic logic [2:0] apply_delete(input logic [15:0] fid);
    int  w;
    bit  hit;
    w = 0;
    hit = 1'b0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_fixture[i] == fid) begin
        hit = 1'b1;
      end else begin
        tbl_fixture[w] = tbl_fixture[i];
        tbl_address[w] = tbl_address[i];
        tbl_level[w] = tbl_level[i];
        w++;
      end
    end
    tbl_count = w;
    if (open_v && open_fid == fid) open_v = 1'b0;
    return hit ? lsfe_pkg::ST_OK : lsfe_pkg::ST_NOT_FOUND;
  endfunction

  task automatic predict_tick();
    logic [15:0] dur;
    bit          done;
    int          v;
    if (mode == lsfe_pkg::MODE_IDLE) begin
      push_result(lsfe_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
      return;
    end
    if (elapsed < 16'hFFFF) elapsed++;
    dur = (mode == lsfe_pkg::MODE_IN) ? fade_in_dur : fade_out_dur;
    done = elapsed >= dur;
    for (int i = 0; i < tbl_count; i++) begin
      if (done) v = (mode == lsfe_pkg::MODE_IN) ? int'(tbl_level[i]) : 0;
      else if (mode == lsfe_pkg::MODE_IN) v = (int'(tbl_level[i]) * int'(elapsed)) / int'(dur);
      else v = int'(tbl_level[i]) - (int'(tbl_level[i]) * int'(elapsed)) / int'(dur);
      push_result(lsfe_pkg::ST_OK, 1'b1, {1'b0, tbl_address[i]} + 10'd1, 8'(v),
                  i + 1 == tbl_count);
    end
    if (tbl_count == 0) push_result(lsfe_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
    if (done) mode = lsfe_pkg::MODE_IDLE;
  endtask

  task automatic predict_item();
    logic [2:0] st;
    st = lsfe_pkg::ST_OK;
    case (in_ch.op)
      lsfe_pkg::OP_ADD: begin
        st = apply_add(in_ch.fix_id, in_ch.base_address, in_ch.channel_offset,
                       in_ch.level, in_ch.first_of_preset);
      end
      lsfe_pkg::OP_DEL: begin
        st = apply_delete(in_ch.fix_id);
      end
      lsfe_pkg::OP_FADE_IN: begin
        elapsed = '0;
        mode = lsfe_pkg::MODE_IN;
      end
      lsfe_pkg::OP_FADE_OUT: begin
        elapsed = '0;
        mode = lsfe_pkg::MODE_OUT;
      end
      lsfe_pkg::OP_TICK: begin
        predict_tick();
        return;
      end
      default: begin
        st = lsfe_pkg::ST_INVALID;
      end
    endcase
    push_result(st, 1'b0, '0, '0, 1'b1);
  endtask

  always @(posedge clk) begin
    chan_result_t got, exp_r;
    if (!rst_n) begin
      expected_q.delete();
      tbl_count = 0;
      mode = lsfe_pkg::MODE_IDLE;
      elapsed = '0;
      open_fid = '0;
      open_v = 1'b0;
      fade_in_dur = '0;
      fade_out_dur = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got = {out_ch.status, out_ch.channel_valid, out_ch.address, out_ch.value, out_ch.last};
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result status=%0d addr=%0d value=%0d",
                           got.status, got.address, got.value));
        end else begin
          exp_r = expected_q.pop_front();
          if (got != exp_r) begin
            report($sformatf({"got st=%0d cv=%0d addr=%0d val=%0d last=%0d, ",
                              "want st=%0d cv=%0d addr=%0d val=%0d last=%0d"},
                             got.status, got.channel_valid, got.address, got.value, got.last,
                             exp_r.status, exp_r.channel_valid, exp_r.address, exp_r.value,
                             exp_r.last));
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == lsfe_pkg::REG_FADE_IN) fade_in_dur = cfg_ch.data;
        else if (cfg_ch.index == lsfe_pkg::REG_FADE_OUT) fade_out_dur = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) predict_item();
    end
    pending = expected_q.size();
  end

endmodule

// File: sim/tb_lighting_scene_fade_engine_core.sv
// tb_lighting_scene_fade_engine_core: stimulus and verdict for the scene fade engine
// depends on lsfe_pkg, the lsfe_*_if interfaces, lighting_scene_fade_engine_core
// and lsfe_scoreboard

module tb_lighting_scene_fade_engine_core;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   results_seen;
  int   item_count;
  int   hold_req;
  bit   quiet;

  lsfe_in_if  in_ch ();
  lsfe_out_if out_ch ();
  lsfe_cfg_if cfg_ch ();

  lighting_scene_fade_engine_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lsfe_scoreboard checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    #20000000;
    $display("tb_lighting_scene_fade_engine_core: errors");
    $finish;
  end

  // result side: random stalls and a long hold when asked
  initial begin
    int hold_taken;
    hold_taken = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_taken) begin
        hold_taken = hold_req;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send(input logic [2:0] op, input logic [15:0] fid, input logic [9:0] base,
                      input logic [8:0] off, input logic [7:0] lvl, input logic first);
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.fix_id <= fid;
    in_ch.base_address <= base;
    in_ch.channel_offset <= off;
    in_ch.level <= lvl;
    in_ch.first_of_preset <= first;
    item_count++;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic send_op(input logic [2:0] op);
    send(op, 16'($urandom), 10'($urandom), 9'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic send_tick();
    send(lsfe_pkg::OP_TICK, '0, '0, '0, '0, 1'b0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_reg(input logic [lsfe_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    forever begin
      @(posedge clk);
      if (cfg_ch.ready) break;
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_preset(input logic [15:0] fid);
    int n;
    n = $urandom_range(0, 5);
    send(lsfe_pkg::OP_ADD, fid, 10'($urandom_range(1, 400)), 9'($urandom_range(0, 100)),
         8'($urandom), 1'b1);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: send(lsfe_pkg::OP_ADD, fid ^ 16'h0001, 10'($urandom_range(1, 400)), 9'($urandom),
                8'($urandom), 1'b0);
        1: send(lsfe_pkg::OP_ADD, fid, 10'($urandom), 9'($urandom), 8'($urandom), 1'b0);
        default: send(lsfe_pkg::OP_ADD, fid, 10'($urandom_range(1, 400)),
                      9'($urandom_range(0, 100)), 8'($urandom), 1'b0);
      endcase
    end
  endtask

  function automatic logic [15:0] pick_duration();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin
    logic [15:0] fid;
    int          nt;
    item_count = 0;
    hold_req = 0;
    quiet = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= lsfe_pkg::OP_TICK;
    in_ch.fix_id <= '0;
    in_ch.base_address <= '0;
    in_ch.channel_offset <= '0;
    in_ch.level <= '0;
    in_ch.first_of_preset <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= lsfe_pkg::REG_FADE_IN;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cases
    set_reg(lsfe_pkg::REG_FADE_IN, 16'd4);
    set_reg(lsfe_pkg::REG_FADE_OUT, 16'd0);
    send(lsfe_pkg::OP_ADD, 16'h0000, 10'd1, 9'd0, 8'd0, 1'b1);
    send(lsfe_pkg::OP_ADD, 16'h0000, 10'd1, 9'd511, 8'd255, 1'b0);
    send(lsfe_pkg::OP_ADD, 16'h0000, 10'd512, 9'd1, 8'd9, 1'b0);
    send(lsfe_pkg::OP_ADD, 16'h0000, 10'd0, 9'd3, 8'd9, 1'b0);
    send(lsfe_pkg::OP_ADD, 16'hFFFF, 10'd512, 9'd0, 8'd255, 1'b0);
    send(lsfe_pkg::OP_ADD, 16'hFFFF, 10'd512, 9'd0, 8'h80, 1'b1);
    send(lsfe_pkg::OP_ADD, 16'h0000, 10'd5, 9'd5, 8'd5, 1'b1);
    send(lsfe_pkg::OP_ADD, 16'hFFFF, 10'd7, 9'd0, 8'd7, 1'b0);
    send(lsfe_pkg::OP_ADD, 16'hFFFF, 10'h3FF, 9'h1FF, 8'hFF, 1'b1);
    send(lsfe_pkg::OP_DEL, 16'h1234, '0, '0, '0, 1'b0);
    send_tick();
    send(3'd5, 16'hAAAA, 10'h155, 9'h0AA, 8'h55, 1'b1);
    send(3'd6, '0, '0, '0, '0, 1'b0);
    send(3'd7, 16'hFFFF, 10'h3FF, 9'h1FF, 8'hFF, 1'b1);
    send(lsfe_pkg::OP_FADE_IN, '0, '0, '0, '0, 1'b0);
    repeat (5) send_tick();
    send(lsfe_pkg::OP_FADE_IN, '0, '0, '0, '0, 1'b0);
    send_tick();
    send(lsfe_pkg::OP_FADE_OUT, '0, '0, '0, '0, 1'b0);
    send_tick();
    send(lsfe_pkg::OP_ADD, 16'h0042, 10'd20, 9'd0, 8'd30, 1'b1);
    send(lsfe_pkg::OP_DEL, 16'h0042, '0, '0, '0, 1'b0);
    send(lsfe_pkg::OP_ADD, 16'h0042, 10'd21, 9'd0, 8'd30, 1'b0);
    send(lsfe_pkg::OP_DEL, 16'h0000, '0, '0, '0, 1'b0);
    send(lsfe_pkg::OP_DEL, 16'hFFFF, '0, '0, '0, 1'b0);
    send(lsfe_pkg::OP_FADE_IN, '0, '0, '0, '0, 1'b0);
    send_tick();
    drain();

    // fill the table, then overflow it
    set_reg(lsfe_pkg::REG_FADE_IN, 16'hFFFF);
    set_reg(lsfe_pkg::REG_FADE_OUT, 16'd3);
    for (int p = 0; p < 8; p++) begin
      for (int c = 0; c < 8; c++) begin
        send(lsfe_pkg::OP_ADD, 16'(100 + p), 10'(1 + p * 60), 9'(c), 8'($urandom), c == 0);
      end
    end
    send(lsfe_pkg::OP_ADD, 16'd107, 10'd300, 9'd0, 8'd1, 1'b0);
    send(lsfe_pkg::OP_ADD, 16'd999, 10'd300, 9'd0, 8'd1, 1'b1);
    send(lsfe_pkg::OP_FADE_IN, '0, '0, '0, '0, 1'b0);
    hold_req++;
    send_tick();
    send_tick();
    drain();
    send(lsfe_pkg::OP_FADE_OUT, '0, '0, '0, '0, 1'b0);
    send(lsfe_pkg::OP_DEL, 16'd101, '0, '0, '0, 1'b0);
    send(lsfe_pkg::OP_DEL, 16'd104, '0, '0, '0, 1'b0);
    repeat (3) send_tick();
    drain();

    // random phases, the last one without idling
    for (int ph = 0; ph < 2; ph++) begin
      set_reg(lsfe_pkg::REG_FADE_IN, pick_duration());
      set_reg(lsfe_pkg::REG_FADE_OUT, pick_duration());
      if (ph == 1) quiet = 1'b1;
      for (int k = 0; k < 3; k++) begin
        fid = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: random_preset(fid);
          4: send(lsfe_pkg::OP_DEL, fid, 10'($urandom), 9'($urandom), 8'($urandom),
                  1'($urandom));
          5, 6: begin
            send(($urandom_range(0, 1) == 0) ? lsfe_pkg::OP_FADE_IN : lsfe_pkg::OP_FADE_OUT,
                 fid, '0, '0, '0, 1'b0);
            nt = $urandom_range(1, 6);
            repeat (nt) send_tick();
          end
          7: send_tick();
          default: send_op(3'($urandom));
        endcase
      end
      drain();
    end

    in_ch.valid <= 1'b0;
    begin : wait_empty
      for (int w = 0; w < 200000; w++) begin
        @(posedge clk);
        if (pending == 0) disable wait_empty;
      end
    end
    repeat (50) @(posedge clk);
    $display("covered %0d ops (adds, deletes, fades, ticks, unknown ops) and %0d results",
             item_count, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_lighting_scene_fade_engine_core: clean");
    end else begin
      $display("tb_lighting_scene_fade_engine_core: errors");
    end
    $finish;
  end

endmodule
